>>> rtl/arlp_pkg.sv
// Shared types, character constants and small lookup functions for the
// HTTP action result line parser. No dependencies.
package arlp_pkg;

  localparam logic [3:0] PrefixLast = 4'd11;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [5:0] AsciiZero6 = 6'd48;

  typedef enum logic [4:0] {
    PH_SEARCH = 5'b00001,
    PH_SPACES = 5'b00010,
    PH_METHOD = 5'b00100,
    PH_STATUS = 5'b01000,
    PH_LENGTH = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        prefix_found;
    logic [7:0]  method_code;
    logic        status_valid;
    logic [5:0]  status_hundreds;
    logic [5:0]  status_tens;
    logic [5:0]  status_ones;
    logic        length_valid;
    logic [31:0] response_length;
  } arlp_result_t;

  // "+HTTPACTION:"
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h2B;
      4'd1:    ch = 8'h48;
      4'd2:    ch = 8'h54;
      4'd3:    ch = 8'h54;
      4'd4:    ch = 8'h50;
      4'd5:    ch = 8'h41;
      4'd6:    ch = 8'h43;
      4'd7:    ch = 8'h54;
      4'd8:    ch = 8'h49;
      4'd9:    ch = 8'h4F;
      4'd10:   ch = 8'h4E;
      4'd11:   ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // BCD of (k * (1000 - 2^32 mod 1000)) mod 1000: folds 32-bit wrap into the
  // running status residue.
  function automatic logic [11:0] wrap_fix_bcd(input logic [3:0] k);
    logic [11:0] v;
    case (k)
      4'd0:    v = 12'h000;
      4'd1:    v = 12'h704;
      4'd2:    v = 12'h408;
      4'd3:    v = 12'h112;
      4'd4:    v = 12'h816;
      4'd5:    v = 12'h520;
      4'd6:    v = 12'h224;
      4'd7:    v = 12'h928;
      4'd8:    v = 12'h632;
      4'd9:    v = 12'h336;
      default: v = 12'h000;
    endcase
    return v;
  endfunction

  // One BCD digit add; returns {carry, digit}.
  function automatic logic [4:0] bcd_digit_add(input logic [3:0] a, input logic [3:0] b,
                                               input logic cin);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b} + {4'b0, cin};
    if (s >= 5'd10) begin
      s = s - 5'd10;
      return {1'b1, s[3:0]};
    end
    return {1'b0, s[3:0]};
  endfunction

endpackage

>>> rtl/arlp_parse_core.sv
// Per-byte parse state and its next-state logic, plus the result assembled
// from the state after the current byte. Depends on arlp_pkg.
module arlp_parse_core
  import arlp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   line_byte,
  input  logic         end_of_line,
  output arlp_result_t result
);

  logic [3:0]  match_pos, match_pos_next;
  phase_t      phase, phase_next;
  logic        run_open, run_open_next;
  logic [7:0]  method_val, method_val_next;
  logic [31:0] status_val, status_val_next;
  logic [11:0] status_bcd, status_bcd_next;
  logic [31:0] length_val, length_val_next;
  logic        string_ended, string_ended_next;

  logic        is_dig;
  logic        take;
  logic [3:0]  dig;
  logic [7:0]  method_mac;
  logic [35:0] status_mac;
  logic [31:0] length_mac;
  logic [11:0] fix;
  logic [11:0] shifted;
  logic [4:0]  sum_ones, sum_tens, sum_hund;
  logic [11:0] bcd_mac;
  logic        found, st_ok, len_ok;

  assign is_dig = (line_byte >= ChZero) && (line_byte <= ChNine);
  assign dig    = line_byte[3:0];
  assign take   = run_open && is_dig;

  assign method_mac = {method_val[4:0], 3'b0} + {method_val[6:0], 1'b0} + {4'b0, dig};
  assign status_mac = {1'b0, status_val, 3'b0} + {3'b0, status_val, 1'b0} + {32'b0, dig};
  assign length_mac = {length_val[28:0], 3'b0} + {length_val[30:0], 1'b0} + {28'b0, dig};

  // residue mod 1000 kept in BCD: shift in the digit, then correct for wrap
  assign fix      = wrap_fix_bcd(status_mac[35:32]);
  assign shifted  = {status_bcd[7:0], dig};
  assign sum_ones = bcd_digit_add(shifted[3:0], fix[3:0], 1'b0);
  assign sum_tens = bcd_digit_add(shifted[7:4], fix[7:4], sum_ones[4]);
  assign sum_hund = bcd_digit_add(shifted[11:8], fix[11:8], sum_tens[4]);
  assign bcd_mac  = {sum_hund[3:0], sum_tens[3:0], sum_ones[3:0]};

  always_comb begin
    match_pos_next    = match_pos;
    phase_next        = phase;
    run_open_next     = run_open;
    method_val_next   = method_val;
    status_val_next   = status_val;
    status_bcd_next   = status_bcd;
    length_val_next   = length_val;
    string_ended_next = string_ended;
    if (!string_ended) begin
      if (line_byte == ChNul) begin
        string_ended_next = 1'b1;
      end else begin
        unique case (phase)
          PH_SEARCH: begin
            if ((match_pos <= PrefixLast) && (line_byte == prefix_char(match_pos))) begin
              if (match_pos == PrefixLast) begin
                match_pos_next = 4'd0;
                phase_next     = PH_SPACES;
              end else begin
                match_pos_next = match_pos + 4'd1;
              end
            end else begin
              match_pos_next = (line_byte == ChPlus) ? 4'd1 : 4'd0;
            end
          end
          PH_SPACES, PH_METHOD: begin
            if (!((phase == PH_SPACES) && (line_byte == ChSpace))) begin
              phase_next = PH_METHOD;
              if (take) method_val_next = method_mac;
              else run_open_next = 1'b0;
              if (line_byte == ChComma) begin
                phase_next    = PH_STATUS;
                run_open_next = 1'b1;
              end
            end
          end
          PH_STATUS: begin
            if (take) begin
              status_val_next = status_mac[31:0];
              status_bcd_next = bcd_mac;
            end else begin
              run_open_next = 1'b0;
            end
            if (line_byte == ChComma) begin
              phase_next    = PH_LENGTH;
              run_open_next = 1'b1;
            end
          end
          PH_LENGTH: begin
            if (take) length_val_next = length_mac;
            else run_open_next = 1'b0;
          end
          default: phase_next = PH_SEARCH;
        endcase
      end
    end
  end

  assign found  = (phase_next != PH_SEARCH);
  assign st_ok  = (phase_next == PH_STATUS) || (phase_next == PH_LENGTH);
  assign len_ok = (phase_next == PH_LENGTH);

  always_comb begin
    result.prefix_found    = found;
    result.method_code     = found ? method_val_next : 8'd0;
    result.status_valid    = st_ok;
    result.status_hundreds = st_ok ? AsciiZero6 + {2'b0, status_bcd_next[11:8]} : 6'd0;
    result.status_tens     = st_ok ? AsciiZero6 + {2'b0, status_bcd_next[7:4]} : 6'd0;
    result.status_ones     = st_ok ? AsciiZero6 + {2'b0, status_bcd_next[3:0]} : 6'd0;
    result.length_valid    = len_ok;
    result.response_length = len_ok ? length_val_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_line)) begin
      match_pos    <= 4'd0;
      phase        <= PH_SEARCH;
      run_open     <= 1'b1;
      method_val   <= 8'd0;
      status_val   <= 32'd0;
      status_bcd   <= 12'd0;
      length_val   <= 32'd0;
      string_ended <= 1'b0;
    end else if (step) begin
      match_pos    <= match_pos_next;
      phase        <= phase_next;
      run_open     <= run_open_next;
      method_val   <= method_val_next;
      status_val   <= status_val_next;
      status_bcd   <= status_bcd_next;
      length_val   <= length_val_next;
      string_ended <= string_ended_next;
    end
  end

endmodule

>>> rtl/action_result_line_parser_unit.sv
// Top level of the HTTP action result line parser: input register, parse core
// and result register. Depends on arlp_pkg and arlp_parse_core.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   line_byte, end_of_line
//   output   out_valid / out_ready prefix_found .. response_length
//
// One request a cycle is taken while no last byte is stalled by a held result;
// a line's last byte is held in the input register, then parsed into the
// result register once the output is free, where its result becomes valid.
// The per-byte state update (a 36-bit multiply-by-ten add) bounds the clock.
// Synchronous reset clears both registers' valid flags and the parse state.
// A held result stalls only a pending last byte; other bytes keep flowing.
module action_result_line_parser_unit
  import arlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  line_byte,
  input  logic        end_of_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        prefix_found,
  output logic [7:0]  method_code,
  output logic        status_valid,
  output logic [5:0]  status_hundreds,
  output logic [5:0]  status_tens,
  output logic [5:0]  status_ones,
  output logic        length_valid,
  output logic [31:0] response_length
);

  logic         hold_valid;
  logic [7:0]   hold_byte;
  logic         hold_eol;
  logic         res_free;
  logic         step;
  arlp_result_t core_result;
  arlp_result_t result;

  assign res_free = !out_valid || out_ready;
  assign step     = hold_valid && (!hold_eol || res_free);
  assign in_ready = !hold_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (step) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= line_byte;
      hold_eol  <= end_of_line;
    end
  end

  arlp_parse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .line_byte   (hold_byte),
    .end_of_line (hold_eol),
    .result      (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && hold_eol) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hold_eol) begin
      result <= core_result;
    end
  end

  assign prefix_found    = result.prefix_found;
  assign method_code     = result.method_code;
  assign status_valid    = result.status_valid;
  assign status_hundreds = result.status_hundreds;
  assign status_tens     = result.status_tens;
  assign status_ones     = result.status_ones;
  assign length_valid    = result.length_valid;
  assign response_length = result.response_length;

endmodule
